[rtl/phf_pkg.sv]
// ----------------------------------------------------------------------------
// phf_pkg: shared types and helpers of the peer handshake tracker
// Holds the action codes, the command and result beat formats and the
// saturation helper used by the front and the back.
// ----------------------------------------------------------------------------
package phf_pkg;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FAIL,
    ACT_HELLO,
    ACT_HELLO_ACK,
    ACT_GET_ADDR,
    ACT_ADDR,
    ACT_TICK,
    ACT_CONNECT
  } act_e;

  typedef struct packed {
    act_e               act;
    logic [31:0]        now;
    logic               ver_nz;
    logic signed [31:0] hello_off;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         send_message;
    logic               handshaked;
    logic               link_fail;
    logic [3:0]         link_state;
    logic signed [31:0] clock_offset;
    logic               last_result;
  } res_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/phf_front.sv]
// ----------------------------------------------------------------------------
// phf_front: input classifier
// Turns an input beat into one action code and precomputes the saturated
// hello clock offset, so the back only has to carry the action out.
// ----------------------------------------------------------------------------
module phf_front (
  input  logic [1:0]    opcode_i,
  input  logic [2:0]    command_i,
  input  logic          network_channel_i,
  input  logic          packet_ok_i,
  input  logic [31:0]   now_time_i,
  input  logic [30:0]   peer_version_i,
  input  logic [31:0]   peer_time_i,
  output phf_pkg::cmd_t cmd_o
);
  import phf_pkg::*;

  localparam logic [1:0] OPC_PACKET  = 2'd0;
  localparam logic [1:0] OPC_TICK    = 2'd1;
  localparam logic [1:0] OPC_CONNECT = 2'd2;

  localparam logic [2:0] CMD_HELLO     = 3'd0;
  localparam logic [2:0] CMD_HELLO_ACK = 3'd1;
  localparam logic [2:0] CMD_GET_ADDR  = 3'd2;
  localparam logic [2:0] CMD_ADDR      = 3'd3;

  logic signed [33:0] off_diff;
  act_e               act;

  always_comb begin
    act = ACT_NONE;
    case (opcode_i)
      OPC_PACKET: begin
        if (!packet_ok_i) begin
          act = ACT_FAIL;
        end else if (network_channel_i) begin
          case (command_i)
            CMD_HELLO:     act = ACT_HELLO;
            CMD_HELLO_ACK: act = ACT_HELLO_ACK;
            CMD_GET_ADDR:  act = ACT_GET_ADDR;
            CMD_ADDR:      act = ACT_ADDR;
            default:       act = ACT_NONE;
          endcase
        end
      end
      OPC_TICK:    act = ACT_TICK;
      OPC_CONNECT: act = ACT_CONNECT;
      default:     act = ACT_NONE;
    endcase
  end

  assign off_diff = $signed({2'b00, peer_time_i}) - $signed({2'b00, now_time_i});

  assign cmd_o.act       = act;
  assign cmd_o.now       = now_time_i;
  assign cmd_o.ver_nz    = |peer_version_i;
  assign cmd_o.hello_off = sat32(off_diff);

endmodule

[rtl/phf_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// phf_cmd_fifo: two-entry command queue
// Decouples the classifier from the sequencer so each side stalls alone.
// ----------------------------------------------------------------------------
module phf_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  phf_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output phf_pkg::cmd_t data_o
);
  import phf_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign valid_o = |cnt_q;
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = wp_q ^ do_push;
    rp_d  = rp_q ^ do_pop;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("command queue count out of range");

endmodule

[rtl/phf_back.sv]
// ----------------------------------------------------------------------------
// phf_back: handshake sequencer and result queue
// Carries out one action per visit: decides the transition, then applies any
// round-trip correction and writes one or two result beats to the queue.
// ----------------------------------------------------------------------------
module phf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          cmd_valid_i,
  input  phf_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output phf_pkg::res_t res_o
);
  import phf_pkg::*;

  localparam logic [3:0] ST_IN_CONNECTED   = 4'd1;
  localparam logic [3:0] ST_IN_WAIT_ACK    = 4'd2;
  localparam logic [3:0] ST_IN_HANDSHAKED  = 4'd3;
  localparam logic [3:0] ST_IN_WAIT_ADDR   = 4'd4;
  localparam logic [3:0] ST_IN_COMPLETE    = 4'd5;
  localparam logic [3:0] ST_OUT_CONNECT    = 4'd6;
  localparam logic [3:0] ST_OUT_CONNECTED  = 4'd7;
  localparam logic [3:0] ST_OUT_WAIT_HEL   = 4'd8;
  localparam logic [3:0] ST_OUT_HANDSHAKED = 4'd9;
  localparam logic [3:0] ST_OUT_WAIT_ADDR  = 4'd10;
  localparam logic [3:0] ST_OUT_COMPLETE   = 4'd11;

  localparam logic [2:0] MSG_NONE     = 3'd0;
  localparam logic [2:0] MSG_HELLO    = 3'd1;
  localparam logic [2:0] MSG_HELLO_AK = 3'd2;
  localparam logic [2:0] MSG_GET_ADDR = 3'd3;
  localparam logic [2:0] MSG_ADDR     = 3'd4;

  localparam logic [1:0] SEQ_EXEC   = 2'd0;
  localparam logic [1:0] SEQ_FIN    = 2'd1;
  localparam logic [1:0] SEQ_SECOND = 2'd2;

  function automatic logic [5:0] limit_of(input logic [3:0] s);
    logic [5:0] r;
    case (s)
      ST_IN_CONNECTED, ST_IN_HANDSHAKED, ST_OUT_HANDSHAKED: r = 6'd30;
      ST_IN_WAIT_ACK, ST_IN_WAIT_ADDR,
      ST_OUT_WAIT_HEL, ST_OUT_WAIT_ADDR:                    r = 6'd10;
      ST_IN_COMPLETE, ST_OUT_COMPLETE:                      r = 6'd2;
      ST_OUT_CONNECT, ST_OUT_CONNECTED:                     r = 6'd20;
      default:                                              r = 6'd0;
    endcase
    return r;
  endfunction

  logic               inbound_q, inbound_d;
  logic [3:0]         state_q, state_d;
  logic [31:0]        start_q, start_d;
  logic [31:0]        hs_time_q, hs_time_d;
  logic               seen_q, seen_d;
  logic signed [31:0] off_q, off_d;
  logic [1:0]         seq_q, seq_d;
  logic [2:0]         send0_q, send0_d;
  logic [2:0]         send1_q, send1_d;
  logic               two_q, two_d;
  logic               hs_q, hs_d;
  logic               fail_q, fail_d;
  logic               add_q, add_d;
  logic signed [31:0] half_q, half_d;

  res_t       out_mem_q [2];
  logic       out_wp_q, out_rp_q;
  logic [1:0] out_cnt_q;
  logic       out_full, out_push, out_pop;
  res_t       res_d;

  logic signed [32:0] rtt;
  logic [32:0]        elapsed;
  logic [5:0]         lim;
  logic signed [31:0] off_fin;

  assign out_full = out_cnt_q[1];
  assign out_pop  = pop_i && (out_cnt_q != 2'd0);
  assign empty_o  = out_cnt_q == 2'd0;
  assign res_o    = out_mem_q[out_rp_q];

  assign rtt     = $signed({1'b0, cmd_i.now}) - $signed({1'b0, hs_time_q});
  assign elapsed = {1'b0, cmd_i.now} - {1'b0, start_q};
  assign lim     = limit_of(state_q);
  assign off_fin = add_q ? sat32({{2{off_q[31]}}, off_q} + {{2{half_q[31]}}, half_q})
                         : off_q;

  always_comb begin
    inbound_d = inbound_q;
    state_d   = state_q;
    start_d   = start_q;
    hs_time_d = hs_time_q;
    seen_d    = seen_q;
    off_d     = off_q;
    seq_d     = seq_q;
    send0_d   = send0_q;
    send1_d   = send1_q;
    two_d     = two_q;
    hs_d      = hs_q;
    fail_d    = fail_q;
    add_d     = add_q;
    half_d    = half_q;
    cmd_pop_o = 1'b0;
    out_push  = 1'b0;
    res_d     = '0;

    case (seq_q)
      SEQ_EXEC: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          seq_d     = SEQ_FIN;
          send0_d   = MSG_NONE;
          send1_d   = MSG_NONE;
          two_d     = 1'b0;
          hs_d      = 1'b0;
          fail_d    = 1'b0;
          add_d     = 1'b0;
          half_d    = rtt[32:1] + {31'd0, rtt[32] & rtt[0]};
          case (cmd_i.act)
            ACT_FAIL: fail_d = 1'b1;
            ACT_HELLO: begin
              if (seen_q) begin
                fail_d = 1'b1;
              end else begin
                seen_d = cmd_i.ver_nz;
                off_d  = cmd_i.hello_off;
                if (inbound_q) begin
                  if (state_q == ST_IN_CONNECTED) begin
                    send0_d   = MSG_HELLO;
                    hs_time_d = cmd_i.now;
                    state_d   = ST_IN_WAIT_ACK;
                    start_d   = cmd_i.now;
                  end else begin
                    fail_d = 1'b1;
                  end
                end else if (state_q == ST_OUT_WAIT_HEL) begin
                  state_d = ST_OUT_WAIT_ADDR;
                  start_d = cmd_i.now;
                  add_d   = 1'b1;
                  hs_d    = 1'b1;
                  send0_d = MSG_HELLO_AK;
                  send1_d = MSG_GET_ADDR;
                  two_d   = 1'b1;
                end else begin
                  fail_d = 1'b1;
                end
              end
            end
            ACT_HELLO_ACK: begin
              if (inbound_q) begin
                if (state_q == ST_IN_WAIT_ACK && seen_q) begin
                  state_d = ST_IN_WAIT_ADDR;
                  start_d = cmd_i.now;
                  add_d   = 1'b1;
                  hs_d    = 1'b1;
                  send0_d = MSG_GET_ADDR;
                end else begin
                  fail_d = 1'b1;
                end
              end
            end
            ACT_GET_ADDR: send0_d = MSG_ADDR;
            ACT_ADDR: begin
              if (state_q == ST_IN_WAIT_ADDR) begin
                state_d = ST_IN_COMPLETE;
                start_d = cmd_i.now;
              end else if (state_q == ST_OUT_WAIT_ADDR) begin
                state_d = ST_OUT_COMPLETE;
                start_d = cmd_i.now;
              end else begin
                fail_d = 1'b1;
              end
            end
            ACT_TICK: begin
              if (lim != 6'd0 && !elapsed[32] && elapsed[31:0] >= {26'd0, lim}) begin
                fail_d = 1'b1;
              end
            end
            ACT_CONNECT: begin
              send0_d   = MSG_HELLO;
              hs_time_d = cmd_i.now;
              state_d   = ST_OUT_WAIT_HEL;
              start_d   = cmd_i.now;
            end
            default: ;
          endcase
        end
      end
      SEQ_FIN: begin
        if (!out_full) begin
          out_push           = 1'b1;
          off_d              = off_fin;
          res_d.send_message = send0_q;
          res_d.handshaked   = hs_q && !two_q;
          res_d.link_fail    = fail_q && !two_q;
          res_d.link_state   = state_q;
          res_d.clock_offset = off_fin;
          res_d.last_result  = !two_q;
          seq_d              = two_q ? SEQ_SECOND : SEQ_EXEC;
        end
      end
      SEQ_SECOND: begin
        if (!out_full) begin
          out_push           = 1'b1;
          res_d.send_message = send1_q;
          res_d.handshaked   = hs_q;
          res_d.link_fail    = fail_q;
          res_d.link_state   = state_q;
          res_d.clock_offset = off_q;
          res_d.last_result  = 1'b1;
          seq_d              = SEQ_EXEC;
        end
      end
      default: seq_d = SEQ_EXEC;
    endcase

    if (cfg_we_i) begin
      inbound_d = cfg_wdata_i;
      state_d   = cfg_wdata_i ? ST_IN_CONNECTED : ST_OUT_CONNECT;
      start_d   = '0;
      hs_time_d = '0;
      seen_d    = 1'b0;
      off_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inbound_q <= 1'b0;
      state_q   <= ST_OUT_CONNECT;
      start_q   <= '0;
      hs_time_q <= '0;
      seen_q    <= 1'b0;
      off_q     <= '0;
      seq_q     <= SEQ_EXEC;
      out_wp_q  <= 1'b0;
      out_rp_q  <= 1'b0;
      out_cnt_q <= 2'd0;
    end else begin
      inbound_q <= inbound_d;
      state_q   <= state_d;
      start_q   <= start_d;
      hs_time_q <= hs_time_d;
      seen_q    <= seen_d;
      off_q     <= off_d;
      seq_q     <= seq_d;
      out_wp_q  <= out_wp_q ^ out_push;
      out_rp_q  <= out_rp_q ^ out_pop;
      out_cnt_q <= out_cnt_q + {1'b0, out_push} - {1'b0, out_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    send0_q <= send0_d;
    send1_q <= send1_d;
    two_q   <= two_d;
    hs_q    <= hs_d;
    fail_q  <= fail_d;
    add_q   <= add_d;
    half_q  <= half_d;
    if (out_push) begin
      out_mem_q[out_wp_q] <= res_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> out_cnt_q != 2'd2) else $error("result beat written to a full queue");

  a_hs_not_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !(res_d.handshaked && res_d.link_fail))
    else $error("handshake and failure flagged together");

  a_second_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q == SEQ_SECOND |-> two_q) else $error("second beat without a second send");

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q <= ST_OUT_COMPLETE) else $error("peer state out of range");

endmodule

[rtl/peer_handshake_fsm_top.sv]
// ----------------------------------------------------------------------------
// peer_handshake_fsm_top: handshake tracker for one peer link
// Classifier, command queue and sequencer with its result queue.
// ----------------------------------------------------------------------------
// An input beat is taken on any cycle that the two-entry command queue has
// room; the classifier is combinational. The sequencer works an item in
// steps: decision, then the round-trip offset add and the first result beat,
// then a second result beat when the item asks for two sends. It takes no new
// item until the last one's result beats are written, and its beat steps wait
// while the result queue is full. Result beats wait in a two-entry result
// queue. Configuration writes restart the link state and must come while
// the block is idle.
module peer_handshake_fsm_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [2:0]  command_i,
  input  logic        network_channel_i,
  input  logic        packet_ok_i,
  input  logic [31:0] now_time_i,
  input  logic [30:0] peer_version_i,
  input  logic [31:0] peer_time_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  send_message_o,
  output logic        handshaked_o,
  output logic        link_fail_o,
  output logic [3:0]  link_state_o,
  output logic signed [31:0] clock_offset_o,
  output logic        last_result_o
);
  import phf_pkg::*;

  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_valid;
  logic cmd_pop;
  res_t res;

  phf_front u_front (
    .opcode_i          (opcode_i),
    .command_i         (command_i),
    .network_channel_i (network_channel_i),
    .packet_ok_i       (packet_ok_i),
    .now_time_i        (now_time_i),
    .peer_version_i    (peer_version_i),
    .peer_time_i       (peer_time_i),
    .cmd_o             (cmd_in)
  );

  phf_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_head)
  );

  phf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign send_message_o = res.send_message;
  assign handshaked_o   = res.handshaked;
  assign link_fail_o    = res.link_fail;
  assign link_state_o   = res.link_state;
  assign clock_offset_o = res.clock_offset;
  assign last_result_o  = res.last_result;

endmodule
